>>> design/sha512_pkg.sv
`default_nettype none
package sha512_pkg;

    localparam int WordW = 64;

    typedef struct packed {
        logic [63:0] message_word;
        logic [3:0]  valid_bytes;
        logic        last_word;
    } t_in_item;

    typedef struct packed {
        logic [63:0] digest_word;
        logic [2:0]  word_number;
        logic        digest_done;
    } t_out_item;

    typedef logic [63:0] t_word;

    function automatic t_word rotr(input t_word x, input int n);
        rotr = (x >> n) | (x << (64 - n));
    endfunction

    function automatic t_word round_k(input logic [6:0] i);
        case (i)
            7'd0: round_k = 64'h428A2F98D728AE22;  7'd1: round_k = 64'h7137449123EF65CD;
            7'd2: round_k = 64'hB5C0FBCFEC4D3B2F;  7'd3: round_k = 64'hE9B5DBA58189DBBC;
            7'd4: round_k = 64'h3956C25BF348B538;  7'd5: round_k = 64'h59F111F1B605D019;
            7'd6: round_k = 64'h923F82A4AF194F9B;  7'd7: round_k = 64'hAB1C5ED5DA6D8118;
            7'd8: round_k = 64'hD807AA98A3030242;  7'd9: round_k = 64'h12835B0145706FBE;
            7'd10: round_k = 64'h243185BE4EE4B28C; 7'd11: round_k = 64'h550C7DC3D5FFB4E2;
            7'd12: round_k = 64'h72BE5D74F27B896F; 7'd13: round_k = 64'h80DEB1FE3B1696B1;
            7'd14: round_k = 64'h9BDC06A725C71235; 7'd15: round_k = 64'hC19BF174CF692694;
            7'd16: round_k = 64'hE49B69C19EF14AD2; 7'd17: round_k = 64'hEFBE4786384F25E3;
            7'd18: round_k = 64'h0FC19DC68B8CD5B5; 7'd19: round_k = 64'h240CA1CC77AC9C65;
            7'd20: round_k = 64'h2DE92C6F592B0275; 7'd21: round_k = 64'h4A7484AA6EA6E483;
            7'd22: round_k = 64'h5CB0A9DCBD41FBD4; 7'd23: round_k = 64'h76F988DA831153B5;
            7'd24: round_k = 64'h983E5152EE66DFAB; 7'd25: round_k = 64'hA831C66D2DB43210;
            7'd26: round_k = 64'hB00327C898FB213F; 7'd27: round_k = 64'hBF597FC7BEEF0EE4;
            7'd28: round_k = 64'hC6E00BF33DA88FC2; 7'd29: round_k = 64'hD5A79147930AA725;
            7'd30: round_k = 64'h06CA6351E003826F; 7'd31: round_k = 64'h142929670A0E6E70;
            7'd32: round_k = 64'h27B70A8546D22FFC; 7'd33: round_k = 64'h2E1B21385C26C926;
            7'd34: round_k = 64'h4D2C6DFC5AC42AED; 7'd35: round_k = 64'h53380D139D95B3DF;
            7'd36: round_k = 64'h650A73548BAF63DE; 7'd37: round_k = 64'h766A0ABB3C77B2A8;
            7'd38: round_k = 64'h81C2C92E47EDAEE6; 7'd39: round_k = 64'h92722C851482353B;
            7'd40: round_k = 64'hA2BFE8A14CF10364; 7'd41: round_k = 64'hA81A664BBC423001;
            7'd42: round_k = 64'hC24B8B70D0F89791; 7'd43: round_k = 64'hC76C51A30654BE30;
            7'd44: round_k = 64'hD192E819D6EF5218; 7'd45: round_k = 64'hD69906245565A910;
            7'd46: round_k = 64'hF40E35855771202A; 7'd47: round_k = 64'h106AA07032BBD1B8;
            7'd48: round_k = 64'h19A4C116B8D2D0C8; 7'd49: round_k = 64'h1E376C085141AB53;
            7'd50: round_k = 64'h2748774CDF8EEB99; 7'd51: round_k = 64'h34B0BCB5E19B48A8;
            7'd52: round_k = 64'h391C0CB3C5C95A63; 7'd53: round_k = 64'h4ED8AA4AE3418ACB;
            7'd54: round_k = 64'h5B9CCA4F7763E373; 7'd55: round_k = 64'h682E6FF3D6B2B8A3;
            7'd56: round_k = 64'h748F82EE5DEFB2FC; 7'd57: round_k = 64'h78A5636F43172F60;
            7'd58: round_k = 64'h84C87814A1F0AB72; 7'd59: round_k = 64'h8CC702081A6439EC;
            7'd60: round_k = 64'h90BEFFFA23631E28; 7'd61: round_k = 64'hA4506CEBDE82BDE9;
            7'd62: round_k = 64'hBEF9A3F7B2C67915; 7'd63: round_k = 64'hC67178F2E372532B;
            7'd64: round_k = 64'hCA273ECEEA26619C; 7'd65: round_k = 64'hD186B8C721C0C207;
            7'd66: round_k = 64'hEADA7DD6CDE0EB1E; 7'd67: round_k = 64'hF57D4F7FEE6ED178;
            7'd68: round_k = 64'h06F067AA72176FBA; 7'd69: round_k = 64'h0A637DC5A2C898A6;
            7'd70: round_k = 64'h113F9804BEF90DAE; 7'd71: round_k = 64'h1B710B35131C471B;
            7'd72: round_k = 64'h28DB77F523047D84; 7'd73: round_k = 64'h32CAAB7B40C72493;
            7'd74: round_k = 64'h3C9EBE0A15C9BEBC; 7'd75: round_k = 64'h431D67C49C100D4C;
            7'd76: round_k = 64'h4CC5D4BECB3E42B6; 7'd77: round_k = 64'h597F299CFC657E2A;
            7'd78: round_k = 64'h5FCB6FAB3AD6FAEC; 7'd79: round_k = 64'h6C44198C4A475817;
            default: round_k = 64'h0;
        endcase
    endfunction

    function automatic t_word start_hash(input logic [2:0] i);
        case (i)
            3'd0: start_hash = 64'h6A09E667F3BCC908;
            3'd1: start_hash = 64'hBB67AE8584CAA73B;
            3'd2: start_hash = 64'h3C6EF372FE94F82B;
            3'd3: start_hash = 64'hA54FF53A5F1D36F1;
            3'd4: start_hash = 64'h510E527FADE682D1;
            3'd5: start_hash = 64'h9B05688C2B3E6C1F;
            3'd6: start_hash = 64'h1F83D9ABFB41BD6B;
            3'd7: start_hash = 64'h5BE0CD19137E2179;
            default: start_hash = 64'h0;
        endcase
    endfunction

endpackage
`default_nettype wire

>>> design/sha512_round.sv
`default_nettype none
module sha512_round (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_start,
    input  wire sha512_pkg::t_word  i_hash [8],
    input  wire sha512_pkg::t_word  i_block [16],
    output logic                    o_busy,
    output logic                    o_done,
    output sha512_pkg::t_word       o_sum [8]
);
    logic [6:0]        r_rnd;
    logic              r_busy;
    logic              r_done;
    sha512_pkg::t_word r_w [16];
    sha512_pkg::t_word r_v [8];
    sha512_pkg::t_word n_wnew;
    sha512_pkg::t_word t1;
    sha512_pkg::t_word t2;
    sha512_pkg::t_word s0;
    sha512_pkg::t_word s1;

    always_comb begin
        s0 = sha512_pkg::rotr(r_w[1], 1) ^ sha512_pkg::rotr(r_w[1], 8) ^ (r_w[1] >> 7);
        s1 = sha512_pkg::rotr(r_w[14], 19) ^ sha512_pkg::rotr(r_w[14], 61) ^ (r_w[14] >> 6);
        n_wnew = r_w[0] + s0 + r_w[9] + s1;
        t1 = r_v[7] + (sha512_pkg::rotr(r_v[4], 14) ^ sha512_pkg::rotr(r_v[4], 18)
             ^ sha512_pkg::rotr(r_v[4], 41)) + ((r_v[4] & r_v[5]) ^ (~r_v[4] & r_v[6]))
             + sha512_pkg::round_k(r_rnd) + r_w[0];
        t2 = (sha512_pkg::rotr(r_v[0], 28) ^ sha512_pkg::rotr(r_v[0], 34)
             ^ sha512_pkg::rotr(r_v[0], 39))
             + ((r_v[0] & r_v[1]) ^ (r_v[0] & r_v[2]) ^ (r_v[1] & r_v[2]));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_rnd  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start && !r_busy) begin
                r_busy <= 1'b1;
                r_rnd  <= '0;
            end else if (r_busy) begin
                if (r_rnd == 7'd79) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
                r_rnd <= r_rnd + 7'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start && !r_busy) begin
            r_w <= i_block;
            r_v <= i_hash;
        end else if (r_busy) begin
            for (int k = 0; k < 15; k++) r_w[k] <= r_w[k+1];
            r_w[15] <= n_wnew;
            r_v[7] <= r_v[6]; r_v[6] <= r_v[5]; r_v[5] <= r_v[4];
            r_v[4] <= r_v[3] + t1;
            r_v[3] <= r_v[2]; r_v[2] <= r_v[1]; r_v[1] <= r_v[0];
            r_v[0] <= t1 + t2;
        end
    end

    assign o_busy = r_busy;
    assign o_done = r_done;
    assign o_sum  = r_v;
endmodule
`default_nettype wire

>>> design/sha512_hash_core.sv
// A word is accepted, then its valid bytes are packed one per cycle, pausing while each
// filled block is started on the single round unit, run through 80 rounds and folded in.
// A last word pads one byte per cycle up to the length field (one or two blocks),
// then delivers 8 digest transfers, one per cycle when not stalled.
// A new word is taken only in idle, after the previous word and any filled block are done.
// Reset: synchronous, active low; restores the initial hash, zero length and fill.
`default_nettype none
module sha512_hash_core (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_valid,
    output logic                       o_stall,
    input  wire sha512_pkg::t_in_item  i_data,
    output logic                       o_valid,
    input  wire logic                  i_stall,
    output sha512_pkg::t_out_item      o_data
);
    localparam logic [2:0] S_IDLE = 3'd0, S_RUN = 3'd1, S_WAIT = 3'd2,
                           S_PAD = 3'd3, S_OUT = 3'd4, S_GO = 3'd5;

    logic [2:0]        r_st;
    logic [6:0]        r_fill;
    logic [127:0]      r_len;
    logic [3:0]        r_nb;
    logic [3:0]        r_bi;
    logic [63:0]       r_word;
    logic              r_last;
    logic              r_padded;
    logic              r_final;
    logic [2:0]        r_oi;
    sha512_pkg::t_word r_h [8];
    sha512_pkg::t_word r_blk [16];
    logic              start;
    logic              busy;
    logic              done;
    sha512_pkg::t_word sum [8];
    logic [3:0]        nb;
    logic [7:0]        byte_in;
    logic [5:0]        sh;

    sha512_round u_round (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(start), .i_hash(r_h),
        .i_block(r_blk), .o_busy(busy), .o_done(done), .o_sum(sum)
    );

    assign nb = (i_data.valid_bytes > 4'd8) ? 4'd8 : i_data.valid_bytes;
    assign o_stall = (r_st != S_IDLE);
    assign byte_in = (r_st == S_PAD) ? (r_padded ? 8'h00 : 8'h80)
                     : r_word[63 - {r_bi[2:0], 3'b000} -: 8];
    assign sh = {~r_fill[2:0], 3'b000};
    assign start = (r_st == S_GO) && !busy;
    assign o_valid = (r_st == S_OUT);
    assign o_data.digest_word = r_h[r_oi];
    assign o_data.word_number = r_oi;
    assign o_data.digest_done = (r_oi == 3'd7);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st <= S_IDLE; r_fill <= '0; r_len <= '0; r_oi <= '0;
            r_padded <= 1'b0; r_final <= 1'b0; r_bi <= '0; r_nb <= '0; r_last <= 1'b0;
            for (int k = 0; k < 8; k++) r_h[k] <= sha512_pkg::start_hash(3'(k));
        end else begin
            case (r_st)
                S_IDLE: if (i_valid) begin
                    r_word <= i_data.message_word;
                    r_nb   <= nb;
                    r_bi   <= '0;
                    r_last <= i_data.last_word;
                    r_padded <= 1'b0;
                    r_len  <= r_len + {121'd0, nb, 3'b000};
                    if (nb != 4'd0) r_st <= S_RUN;
                    else if (i_data.last_word) r_st <= S_PAD;
                end
                S_RUN, S_PAD: begin
                    if (r_st == S_PAD && r_padded && r_fill == 7'd112) begin
                        r_blk[14] <= r_len[127:64];
                        r_blk[15] <= r_len[63:0];
                        r_final <= 1'b1;
                        r_st <= S_GO;
                    end else begin
                        r_blk[r_fill[6:3]][sh +: 8] <= byte_in;
                        r_fill <= r_fill + 7'd1;
                        if (r_st == S_PAD) r_padded <= 1'b1;
                        else r_bi <= r_bi + 4'd1;
                        if (r_fill == 7'd127) r_st <= S_GO;
                        else if (r_st == S_RUN && r_bi + 4'd1 == r_nb)
                            r_st <= r_last ? S_PAD : S_IDLE;
                    end
                end
                S_GO: if (!busy) r_st <= S_WAIT;
                S_WAIT: if (done) begin
                    for (int k = 0; k < 8; k++) r_h[k] <= r_h[k] + sum[k];
                    if (r_final) r_st <= S_OUT;
                    else if (r_bi < r_nb) r_st <= S_RUN;
                    else if (r_last) r_st <= S_PAD;
                    else r_st <= S_IDLE;
                end
                S_OUT: if (!i_stall) begin
                    r_oi <= r_oi + 3'd1;
                    if (r_oi == 3'd7) begin
                        r_st <= S_IDLE; r_fill <= '0; r_len <= '0;
                        r_final <= 1'b0; r_padded <= 1'b0;
                        for (int k = 0; k < 8; k++) r_h[k] <= sha512_pkg::start_hash(3'(k));
                    end
                end
                default: r_st <= S_IDLE;
            endcase
        end
    end
endmodule
`default_nettype wire

>>> tb/sha512_hash_core_test.sv
`timescale 1ns / 100ps
`default_nettype none
module sha512_hash_core_test;

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  i_valid;
    logic                  o_stall;
    sha512_pkg::t_in_item  i_data;
    logic                  o_valid;
    logic                  i_stall;
    sha512_pkg::t_out_item o_data;

    sha512_hash_core dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_stall (o_stall),
        .i_data  (i_data),
        .o_valid (o_valid),
        .i_stall (i_stall),
        .o_data  (o_data)
    );

    localparam logic [63:0] RoundConst [80] = '{
        64'h428A2F98D728AE22, 64'h7137449123EF65CD, 64'hB5C0FBCFEC4D3B2F, 64'hE9B5DBA58189DBBC,
        64'h3956C25BF348B538, 64'h59F111F1B605D019, 64'h923F82A4AF194F9B, 64'hAB1C5ED5DA6D8118,
        64'hD807AA98A3030242, 64'h12835B0145706FBE, 64'h243185BE4EE4B28C, 64'h550C7DC3D5FFB4E2,
        64'h72BE5D74F27B896F, 64'h80DEB1FE3B1696B1, 64'h9BDC06A725C71235, 64'hC19BF174CF692694,
        64'hE49B69C19EF14AD2, 64'hEFBE4786384F25E3, 64'h0FC19DC68B8CD5B5, 64'h240CA1CC77AC9C65,
        64'h2DE92C6F592B0275, 64'h4A7484AA6EA6E483, 64'h5CB0A9DCBD41FBD4, 64'h76F988DA831153B5,
        64'h983E5152EE66DFAB, 64'hA831C66D2DB43210, 64'hB00327C898FB213F, 64'hBF597FC7BEEF0EE4,
        64'hC6E00BF33DA88FC2, 64'hD5A79147930AA725, 64'h06CA6351E003826F, 64'h142929670A0E6E70,
        64'h27B70A8546D22FFC, 64'h2E1B21385C26C926, 64'h4D2C6DFC5AC42AED, 64'h53380D139D95B3DF,
        64'h650A73548BAF63DE, 64'h766A0ABB3C77B2A8, 64'h81C2C92E47EDAEE6, 64'h92722C851482353B,
        64'hA2BFE8A14CF10364, 64'hA81A664BBC423001, 64'hC24B8B70D0F89791, 64'hC76C51A30654BE30,
        64'hD192E819D6EF5218, 64'hD69906245565A910, 64'hF40E35855771202A, 64'h106AA07032BBD1B8,
        64'h19A4C116B8D2D0C8, 64'h1E376C085141AB53, 64'h2748774CDF8EEB99, 64'h34B0BCB5E19B48A8,
        64'h391C0CB3C5C95A63, 64'h4ED8AA4AE3418ACB, 64'h5B9CCA4F7763E373, 64'h682E6FF3D6B2B8A3,
        64'h748F82EE5DEFB2FC, 64'h78A5636F43172F60, 64'h84C87814A1F0AB72, 64'h8CC702081A6439EC,
        64'h90BEFFFA23631E28, 64'hA4506CEBDE82BDE9, 64'hBEF9A3F7B2C67915, 64'hC67178F2E372532B,
        64'hCA273ECEEA26619C, 64'hD186B8C721C0C207, 64'hEADA7DD6CDE0EB1E, 64'hF57D4F7FEE6ED178,
        64'h06F067AA72176FBA, 64'h0A637DC5A2C898A6, 64'h113F9804BEF90DAE, 64'h1B710B35131C471B,
        64'h28DB77F523047D84, 64'h32CAAB7B40C72493, 64'h3C9EBE0A15C9BEBC, 64'h431D67C49C100D4C,
        64'h4CC5D4BECB3E42B6, 64'h597F299CFC657E2A, 64'h5FCB6FAB3AD6FAEC, 64'h6C44198C4A475817
    };
    localparam logic [63:0] InitHash [8] = '{
        64'h6A09E667F3BCC908, 64'hBB67AE8584CAA73B, 64'h3C6EF372FE94F82B, 64'hA54FF53A5F1D36F1,
        64'h510E527FADE682D1, 64'h9B05688C2B3E6C1F, 64'h1F83D9ABFB41BD6B, 64'h5BE0CD19137E2179
    };
    localparam int LengthPos = 112;

    logic [63:0]  hash_state [8];
    logic [63:0]  msg_block [16];
    logic [127:0] msg_bits;
    int           block_fill;

    sha512_pkg::t_out_item digest_queue [$];
    bit        failed;
    bit        idle_on;
    int        hold_cycles;

    function automatic logic [63:0] ror64(logic [63:0] x, int n);
        return (x >> n) | (x << (64 - n));
    endfunction

    task automatic fold_block();
        logic [63:0] w [80];
        logic [63:0] v [8];
        logic [63:0] s0, s1, t1, t2;
        for (int i = 0; i < 16; i++) w[i] = msg_block[i];
        for (int i = 16; i < 80; i++) begin
            s0 = ror64(w[i-15], 1) ^ ror64(w[i-15], 8) ^ (w[i-15] >> 7);
            s1 = ror64(w[i-2], 19) ^ ror64(w[i-2], 61) ^ (w[i-2] >> 6);
            w[i] = w[i-16] + s0 + w[i-7] + s1;
        end
        v = hash_state;
        for (int i = 0; i < 80; i++) begin
            t1 = v[7] + (ror64(v[4], 14) ^ ror64(v[4], 18) ^ ror64(v[4], 41))
               + ((v[4] & v[5]) ^ (~v[4] & v[6])) + RoundConst[i] + w[i];
            t2 = (ror64(v[0], 28) ^ ror64(v[0], 34) ^ ror64(v[0], 39))
               + ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
            v[7] = v[6]; v[6] = v[5]; v[5] = v[4];
            v[4] = v[3] + t1;
            v[3] = v[2]; v[2] = v[1]; v[1] = v[0];
            v[0] = t1 + t2;
        end
        for (int i = 0; i < 8; i++) hash_state[i] += v[i];
    endtask

    task automatic push_byte(logic [7:0] b);
        msg_block[block_fill / 8][(7 - block_fill % 8) * 8 +: 8] = b;
        block_fill++;
        if (block_fill == 128) begin
            fold_block();
            block_fill = 0;
        end
    endtask

    task automatic restart_hash();
        hash_state = InitHash;
        foreach (msg_block[i]) msg_block[i] = '0;
        msg_bits   = '0;
        block_fill = 0;
    endtask

    task automatic hash_word(sha512_pkg::t_in_item it);
        int n;
        sha512_pkg::t_out_item r;
        n = (it.valid_bytes > 8) ? 8 : int'(it.valid_bytes);
        for (int i = 0; i < n; i++) push_byte(it.message_word[63 - 8 * i -: 8]);
        msg_bits += 128'(n * 8);
        if (it.last_word) begin
            push_byte(8'h80);
            while (block_fill != LengthPos) push_byte(8'h00);
            msg_block[14] = msg_bits[127:64];
            msg_block[15] = msg_bits[63:0];
            fold_block();
            for (int i = 0; i < 8; i++) begin
                r.digest_word = hash_state[i];
                r.word_number = 3'(i);
                r.digest_done = (i == 7);
                digest_queue.push_back(r);
            end
            restart_hash();
        end
    endtask

    initial begin
        i_clk = 0;
        forever #2 i_clk = ~i_clk;
    end

    initial begin
        #40ms;
        $display("FAILED: results differ");
        $finish;
    end

    // output stall: random when idle_on is set, held high while hold_cycles runs down
    always @(posedge i_clk) begin
        if (hold_cycles > 0) begin
            hold_cycles <= hold_cycles - 1;
            i_stall <= 1'b1;
        end else begin
            i_stall <= idle_on && ($urandom_range(99) < 32);
        end
    end

    always @(posedge i_clk) begin
        sha512_pkg::t_out_item exp_item;
        if (i_rst_n && o_valid && !i_stall) begin
            if (digest_queue.size() == 0) begin
                $error("unexpected transfer %h", o_data);
                failed = 1;
            end else begin
                exp_item = digest_queue.pop_front();
                if (o_data.digest_word !== exp_item.digest_word) begin
                    $error("digest_word exp %h got %h", exp_item.digest_word, o_data.digest_word);
                    failed = 1;
                end
                if (o_data.word_number !== exp_item.word_number) begin
                    $error("word_number exp %0d got %0d", exp_item.word_number,
                           o_data.word_number);
                    failed = 1;
                end
                if (o_data.digest_done !== exp_item.digest_done) begin
                    $error("digest_done exp %0d got %0d", exp_item.digest_done,
                           o_data.digest_done);
                    failed = 1;
                end
            end
        end
    end

    task automatic send_word(logic [63:0] w, logic [3:0] nb, logic lw);
        while (idle_on && $urandom_range(99) < 32) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_data  <= '{message_word: w, valid_bytes: nb, last_word: lw};
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        hash_word('{message_word: w, valid_bytes: nb, last_word: lw});
    endtask

    function automatic logic [63:0] rand_word();
        return {$urandom(), $urandom()};
    endfunction

    task automatic wait_drain();
        i_valid <= 1'b0;
        while (digest_queue.size() != 0) @(posedge i_clk);
    endtask

    task automatic test_directed();
        send_word(64'h0, 4'd0, 1'b1);
        wait_drain();
        send_word(64'h6162630000000000, 4'd3, 1'b1);
        send_word(64'hFFFFFFFFFFFFFFFF, 4'd8, 1'b0);
        send_word(64'h1234567890ABCDEF, 4'd15, 1'b0);
        send_word(64'hDEADBEEF00000000, 4'd0, 1'b0);
        send_word(64'hA5A5A5A5A5A5A5A5, 4'd5, 1'b0);
        send_word(64'h0, 4'd8, 1'b1);
        for (int i = 0; i < 14; i++) send_word(rand_word(), 4'd8, 1'b0);
        send_word(rand_word(), 4'd7, 1'b1);
        wait_drain();
    endtask

    task automatic test_random_messages(int n_words);
        int sent;
        int len;
        sent = 0;
        while (sent < n_words) begin
            len = ($urandom_range(9) == 0) ? $urandom_range(40) : $urandom_range(20);
            for (int i = 0; i < len; i++) begin
                send_word(rand_word(), ($urandom_range(9) == 0) ? 4'($urandom_range(15)) : 4'd8,
                          1'b0);
                sent++;
            end
            send_word(rand_word(), 4'($urandom_range(15)), 1'b1);
            sent++;
        end
    endtask

    task automatic test_output_hold();
        hold_cycles <= 600;
        for (int i = 0; i < 3; i++) begin
            send_word(rand_word(), 4'd8, 1'b0);
            send_word(rand_word(), 4'd8, 1'b1);
        end
        wait_drain();
    endtask

    initial begin
        failed      = 0;
        idle_on     = 0;
        hold_cycles = 0;
        i_rst_n     = 0;
        i_valid     = 0;
        i_stall     = 0;
        i_data      = '0;
        restart_hash();
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_directed();
        test_random_messages(60);
        idle_on = 1;
        test_random_messages(130);
        wait_drain();
        test_output_hold();
        wait_drain();
        repeat (200) @(posedge i_clk);
        if (!failed) begin
            $display("PASSED: all results match");
        end else begin
            $display("FAILED: results differ");
        end
        $finish;
    end
endmodule
`default_nettype wire
